FILE: rtl/sli_pkg.sv
// sli_pkg: shared types and codes for the sorted list insert/delete block.
// No dependencies.
package sli_pkg;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	localparam logic FN_INSERT = 1'b0;
	localparam logic FN_DELETE = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_INS_RD  = 5'b00010,
		S_INS_CMP = 5'b00100,
		S_DEL_RD  = 5'b01000,
		S_DEL_CMP = 5'b10000
	} state_t;

endpackage

FILE: rtl/sorted_list_insert_delete.sv
// sorted_list_insert_delete: bounded ascending store of signed 32-bit values.
// Depends on sli_pkg.
//
// channel   dir  signals                    handshake
// command   in   func, value                start && !busy
// result    out  status, count, smallest    done, one cycle, no backpressure
//
// Entries live in a single-port-write / registered-read memory walked by one
// comparator, a read state and a compare state per entry visited.
// Insert: walks down from the top, moving entries not below value up one slot,
// and writes value where a smaller entry or the bottom ends the walk; a full
// store answers ST_FULL at once. Delete: walks every entry from the bottom,
// moving those above the first match down; an empty store answers ST_EMPTY.
// busy is high from acceptance through the done cycle, so the next item is taken
// in the cycle after the result at the earliest. After reset the store is
// empty and a command may be taken at once.
module sorted_list_insert_delete #(
	parameter int CAPACITY = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  func,
	input  logic signed [31:0]    value,
	output logic                  done,
	output sli_pkg::status_t      status,
	output logic [4:0]            count,
	output logic signed [31:0]    smallest
);
	import sli_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	state_t              state_q;
	logic                done_q;
	status_t             status_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       k_q;
	logic                found_q;
	logic signed [31:0]  v_q;
	logic signed [31:0]  min_q;

	logic signed [31:0]  mem [CAPACITY];
	logic signed [31:0]  rdata_q;
	logic                we;
	logic [AW-1:0]       wa;
	logic signed [31:0]  wd;
	logic [AW-1:0]       ra;

	logic [CW+4:0]       cnt_ext;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (we && wa == '0) begin
			min_q <= wd;
		end
	end

	// write/read port control
	always_comb begin
		logic [CW-1:0] km1;
		km1 = k_q - ONE_C;
		we  = 1'b0;
		wa  = k_q[AW-1:0];
		wd  = v_q;
		ra  = k_q[AW-1:0];
		case (state_q)
			S_INS_RD: begin
				ra = km1[AW-1:0];
				if (k_q == '0) begin
					we = 1'b1;
					wa = '0;
				end
			end
			S_INS_CMP: begin
				we = 1'b1;
				if (rdata_q >= v_q) begin
					wd = rdata_q;
				end
			end
			S_DEL_CMP: begin
				we = found_q;
				wa = km1[AW-1:0];
				wd = rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			status_q <= ST_DONE;
			cnt_q    <= '0;
			k_q      <= '0;
			found_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start && !done_q) begin
						found_q <= 1'b0;
						if (func == FN_INSERT) begin
							if (cnt_q == CAP_C) begin
								status_q <= ST_FULL;
								done_q   <= 1'b1;
							end else begin
								k_q     <= cnt_q;
								state_q <= S_INS_RD;
							end
						end else begin
							if (cnt_q == '0) begin
								status_q <= ST_EMPTY;
								done_q   <= 1'b1;
							end else begin
								k_q     <= '0;
								state_q <= S_DEL_RD;
							end
						end
					end
				end
				S_INS_RD: begin
					if (k_q == '0) begin
						cnt_q    <= cnt_q + ONE_C;
						status_q <= ST_DONE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (rdata_q >= v_q) begin
						k_q     <= k_q - ONE_C;
						state_q <= S_INS_RD;
					end else begin
						cnt_q    <= cnt_q + ONE_C;
						status_q <= ST_DONE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_DEL_RD: begin
					if (k_q == cnt_q) begin
						if (found_q) begin
							cnt_q    <= cnt_q - ONE_C;
							status_q <= ST_DONE;
						end else begin
							status_q <= ST_NOT_FOUND;
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DEL_CMP;
					end
				end
				S_DEL_CMP: begin
					if (!found_q && rdata_q == v_q) begin
						found_q <= 1'b1;
					end
					k_q     <= k_q + ONE_C;
					state_q <= S_DEL_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start && !done_q) begin
			v_q <= value;
		end
	end

	assign busy     = (state_q != S_IDLE) || done_q;
	assign done     = done_q;
	assign status   = status_q;
	assign cnt_ext  = {5'b0, cnt_q};
	assign count    = cnt_ext[4:0];
	assign smallest = (cnt_q == '0) ? 32'sd0 : min_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_C)
		else $error("count above capacity");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q == ST_FULL |-> cnt_q == CAP_C)
		else $error("full status with room left");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q == ST_EMPTY |-> cnt_q == '0)
		else $error("empty status with entries held");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

endmodule
